### rtl/lrukv_pkg.sv
package lrukv_pkg;

    // Fixed field widths of the transaction payloads.
    localparam int KEY_W   = 16;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 7;

    // Operation codes.
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // Configuration register indexes.
    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic               cmd;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] data;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic lookup;
        logic touch;
        logic write_val;
        logic evict;
        logic insert;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic is_put;
        logic need_evict;
    } dp_status_t;

endpackage

### rtl/lrukv_ctrl.sv
module lrukv_ctrl
    import lrukv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_EXEC   = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    // The output slot can take a new result when empty or being drained.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // Sequencing of lookup, eviction and the final update.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (status.is_put && !status.hit && status.need_evict) begin
                    cmd.evict = 1'b1;
                end else if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (status.hit) begin
                        cmd.touch     = 1'b1;
                        cmd.write_val = status.is_put;
                    end else if (status.is_put) begin
                        cmd.insert = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // A result is produced only when the final update is issued.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> state_reg == ST_EXEC)
        else $error("result loaded outside the execute step");

    // An accepted transaction always moves the controller to the lookup step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == ST_LOOKUP)
        else $error("lookup did not follow an accepted transaction");

    // A pending result is never overwritten.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !cmd.out_load)
        else $error("pending result overwritten");

endmodule

### rtl/lrukv_dp.sv
module lrukv_dp
    import lrukv_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
)(
    input  logic             aclk,
    input  logic             aresetn,
    input  in_item_t         s_data,
    input  logic [CAP_W-1:0] capacity,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    output out_item_t        m_data
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = (CW > CAP_W) ? CW + 1 : CAP_W + 1;

    // Tags, valid bits and recency ranks sit in flip-flops for parallel match.
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [KEY_W-1:0]       key_reg  [MAX_ENTRIES];
    logic [IW-1:0]          rank_reg [MAX_ENTRIES];
    logic [CW-1:0]          count_reg;

    // Values are held in a memory with a registered read.
    logic [VALUE_W-1:0]     val_mem [MAX_ENTRIES];
    logic [VALUE_W-1:0]     rd_reg;

    // Transaction being worked on and the lookup outcome.
    in_item_t               item_reg;
    logic                   hit_reg;
    logic [IW-1:0]          hit_idx_reg;
    logic [IW-1:0]          hit_rank_reg;
    out_item_t              out_reg;

    logic [MAX_ENTRIES-1:0] match;
    logic [MAX_ENTRIES-1:0] victim;
    logic [IW-1:0]          match_idx;
    logic [IW-1:0]          match_rank;
    logic [IW-1:0]          free_idx;
    logic [IW-1:0]          lru_rank;
    logic [EW-1:0]          cap_ext;
    logic [EW-1:0]          eff_cap;
    logic [IW-1:0]          wr_addr;

    // Parallel tag compare; keys of valid entries are unique.
    always_comb begin
        match_idx  = '0;
        match_rank = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match[i] = valid_reg[i] && (key_reg[i] == item_reg.key);
            if (match[i]) begin
                match_idx  = match_idx | IW'(i);
                match_rank = match_rank | rank_reg[i];
            end
        end
    end

    // The least recent entry holds the rank count-1.
    assign lru_rank = IW'(count_reg - CW'(1));
    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            victim[i] = valid_reg[i] && (rank_reg[i] == lru_rank);
        end
    end

    // Lowest free entry for an insert.
    always_comb begin
        free_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = IW'(i);
            end
        end
    end

    // Effective capacity: zero acts as one, large values saturate.
    assign cap_ext = EW'(capacity);
    always_comb begin
        if (cap_ext == '0) begin
            eff_cap = EW'(1);
        end else if (cap_ext > EW'(MAX_ENTRIES)) begin
            eff_cap = EW'(MAX_ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign status.hit        = hit_reg;
    assign status.is_put     = (item_reg.cmd == CMD_PUT);
    assign status.need_evict = (EW'(count_reg) >= eff_cap) && (count_reg != '0);
    assign m_data            = out_reg;

    // Transaction capture, lookup results and output register.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.lookup) begin
            hit_idx_reg  <= match_idx;
            hit_rank_reg <= match_rank;
        end
        if (cmd.out_load) begin
            out_reg.found <= hit_reg;
            out_reg.data  <= (hit_reg && item_reg.cmd == CMD_GET) ? rd_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (cmd.lookup) begin
            hit_reg <= |match;
        end
    end

    // Value memory: one write port, one registered read port.
    assign wr_addr = cmd.insert ? free_idx : hit_idx_reg;
    always_ff @(posedge aclk) begin
        if (cmd.write_val || cmd.insert) begin
            val_mem[wr_addr] <= item_reg.value;
        end
        if (cmd.lookup) begin
            rd_reg <= val_mem[match_idx];
        end
    end

    // Keys are written on insert only.
    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            key_reg[free_idx] <= item_reg.key;
        end
    end

    // Valid bits, recency ranks and the entry count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            if (cmd.evict) begin
                count_reg <= count_reg - CW'(1);
            end else if (cmd.insert) begin
                count_reg <= count_reg + CW'(1);
            end
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (cmd.evict && victim[i]) begin
                    valid_reg[i] <= 1'b0;
                    rank_reg[i]  <= '0;
                end else if (cmd.insert) begin
                    if (IW'(i) == free_idx) begin
                        valid_reg[i] <= 1'b1;
                        rank_reg[i]  <= '0;
                    end else if (valid_reg[i]) begin
                        rank_reg[i] <= rank_reg[i] + IW'(1);
                    end
                end else if (cmd.touch) begin
                    if (IW'(i) == hit_idx_reg) begin
                        rank_reg[i] <= '0;
                    end else if (valid_reg[i] && rank_reg[i] < hit_rank_reg) begin
                        rank_reg[i] <= rank_reg[i] + IW'(1);
                    end
                end
            end
        end
    end

    // The count always equals the number of valid entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CW'($countones(valid_reg)))
        else $error("entry count out of step with valid bits");

    // Eviction picks exactly one entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.evict |-> $onehot(victim))
        else $error("eviction victim not unique");

    // At most one entry matches a key.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match))
        else $error("duplicate keys held");

    // An insert always finds a free entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |-> !(&valid_reg))
        else $error("insert into a full store");

endmodule

### rtl/lru_key_value_cache.sv
// An accepted get or put passes through capture, tag match and update before its result.
// A put of a new key into a full store first evicts least recent entries until the count is below the capacity.
// The controller handles one transaction at a time and takes no new one until the result is loaded.
// Reset (aresetn low, synchronous): all entries invalid, count zero, capacity 64.
// Keys and values are not cleared; they are read only where an entry is valid.
module lru_key_value_cache
    import lrukv_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CAP_W-1:0] capacity_reg;
    dp_cmd_t          cmd;
    dp_status_t       status;

    // Configuration register access.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_W'(64);
        end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    lrukv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lrukv_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .capacity (capacity_reg),
        .cmd      (cmd),
        .status   (status),
        .m_data   (m_data)
    );

endmodule

### sim/lru_key_value_cache_tb.sv
module lru_key_value_cache_tb;
    import lrukv_pkg::*;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    lru_key_value_cache dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Shadow copy of the cache contents and recency order.
    logic [KEY_W-1:0]   shadow_key[DEPTH];
    logic [VALUE_W-1:0] shadow_val[DEPTH];
    bit                 shadow_vld[DEPTH];
    int unsigned        shadow_rank[DEPTH];
    int unsigned        shadow_count;
    logic [CAP_W-1:0]   shadow_cap;

    out_item_t pending_results[$];
    int        mismatch_count = 0;
    int        cycle_count = 0;
    bit        hold_off = 1'b0;
    bit        stall_enable = 1'b1;

    // A key pool keeps hits frequent in the random part.
    logic [KEY_W-1:0] key_pool[16];

    function automatic void shadow_clear();
        for (int i = 0; i < DEPTH; i++) begin
            shadow_vld[i] = 1'b0;
            shadow_rank[i] = 0;
        end
        shadow_count = 0;
        shadow_cap = 7'd64;
    endfunction

    // Move one entry to the front; younger entries age by one.
    function automatic void promote(int idx);
        int unsigned r;
        r = shadow_rank[idx];
        for (int i = 0; i < DEPTH; i++)
            if (shadow_vld[i] && shadow_rank[i] < r) shadow_rank[i]++;
        shadow_rank[idx] = 0;
    endfunction

    function automatic void drop_oldest();
        int victim;
        victim = -1;
        for (int i = 0; i < DEPTH; i++)
            if (shadow_vld[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
                victim = i;
        if (victim >= 0) begin
            shadow_vld[victim] = 1'b0;
            shadow_rank[victim] = 0;
            if (shadow_count > 0) shadow_count--;
        end
    endfunction

    // Compute the response of one transaction and advance the shadow state.
    function automatic out_item_t cache_response(in_item_t item);
        out_item_t res;
        int hit_idx;
        int slot;
        int unsigned cap;
        hit_idx = -1;
        slot = 0;
        for (int i = 0; i < DEPTH; i++)
            if (hit_idx < 0 && shadow_vld[i] && shadow_key[i] == item.key) hit_idx = i;
        res.found = (hit_idx >= 0);
        res.data = '0;
        if (item.cmd == CMD_GET) begin
            if (hit_idx >= 0) begin
                res.data = shadow_val[hit_idx];
                promote(hit_idx);
            end
        end else if (hit_idx >= 0) begin
            shadow_val[hit_idx] = item.value;
            promote(hit_idx);
        end else begin
            cap = shadow_cap;
            if (cap == 0) cap = 1;
            if (cap > DEPTH) cap = DEPTH;
            while (shadow_count >= cap && shadow_count > 0) drop_oldest();
            for (int i = DEPTH - 1; i >= 0; i--)
                if (!shadow_vld[i]) slot = i;
            for (int i = 0; i < DEPTH; i++)
                if (shadow_vld[i]) shadow_rank[i]++;
            shadow_key[slot] = item.key;
            shadow_val[slot] = item.value;
            shadow_vld[slot] = 1'b1;
            shadow_rank[slot] = 0;
            shadow_count++;
        end
        return res;
    endfunction

    // Offer one transaction and wait for it to be accepted.
    // A typed row is checked against its typed expectation.
    task automatic send_item(in_item_t item, bit typed, out_item_t typed_res);
        out_item_t res;
        res = cache_response(item);
        if (typed && res != typed_res) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("directed row disagrees with shadow: key %h", item.key);
        end
        pending_results.push_back(typed ? typed_res : res);
        s_data <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic idle_sender(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    task automatic write_capacity(logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(4 * REG_CAPACITY); pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        shadow_cap = val[CAP_W-1:0];
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    // Check each returned transaction against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: found %b data %h", m_data.found, m_data.data);
            end else begin
                out_item_t exp_res;
                exp_res = pending_results.pop_front();
                if (m_data.found !== exp_res.found || m_data.data !== exp_res.data) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: found exp %b got %b, data exp %h got %h",
                                 exp_res.found, m_data.found, exp_res.data, m_data.data);
                end
            end
        end
    end

    // Receiver stall pattern, with a long hold-off when requested.
    always @(negedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else if (!stall_enable) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 9) > 2);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lru_key_value_cache_tb: done, errors");
            $finish;
        end
    end

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t res;
    } stim_row_t;

    stim_row_t directed_rows[$];

    function automatic void add_row(logic cmd, logic [15:0] key, logic [31:0] val,
                                    bit typed, logic fnd, logic [31:0] dat);
        stim_row_t row;
        row.item = '{cmd: cmd, key: key, value: val};
        row.typed = typed;
        row.res = '{found: fnd, data: dat};
        directed_rows.push_back(row);
    endfunction

    initial begin
        in_item_t item;
        int burst;
        shadow_clear();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part: empty lookups, extremes, update in place.
        add_row(CMD_GET, 16'h0000, 32'h0, 1, 1'b0, 32'h0);
        add_row(CMD_GET, 16'hFFFF, 32'hFFFFFFFF, 1, 1'b0, 32'h0);
        add_row(CMD_PUT, 16'h0000, 32'hFFFFFFFF, 1, 1'b0, 32'h0);
        add_row(CMD_PUT, 16'hFFFF, 32'h00000000, 1, 1'b0, 32'h0);
        add_row(CMD_GET, 16'h0000, 32'h0, 1, 1'b1, 32'hFFFFFFFF);
        add_row(CMD_GET, 16'hFFFF, 32'h5, 1, 1'b1, 32'h0);
        add_row(CMD_PUT, 16'h0000, 32'hA5A5A5A5, 1, 1'b1, 32'h0);
        add_row(CMD_GET, 16'h0000, 32'h0, 1, 1'b1, 32'hA5A5A5A5);
        add_row(CMD_GET, 16'h1234, 32'h0, 1, 1'b0, 32'h0);
        add_row(CMD_PUT, 16'h5555, 32'h55555555, 0, 0, 0);
        add_row(CMD_PUT, 16'hAAAA, 32'hAAAAAAAA, 0, 0, 0);
        add_row(CMD_GET, 16'hFFFF, 32'h0, 0, 0, 0);
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);
        wait_drained();

        // Lower the capacity below the count: the next new key evicts several entries.
        write_capacity(32'd2);
        send_item('{cmd: CMD_PUT, key: 16'h7777, value: 32'h1}, 0, '0);
        send_item('{cmd: CMD_GET, key: 16'h0000, value: 32'h0}, 0, '0);
        send_item('{cmd: CMD_GET, key: 16'hFFFF, value: 32'h0}, 0, '0);
        wait_drained();
        // Capacity zero behaves as one; values above the store size saturate.
        write_capacity(32'd0);
        send_item('{cmd: CMD_PUT, key: 16'h0001, value: 32'h2}, 0, '0);
        send_item('{cmd: CMD_GET, key: 16'h7777, value: 32'h0}, 0, '0);
        send_item('{cmd: CMD_GET, key: 16'h0001, value: 32'h0}, 0, '0);
        wait_drained();
        write_capacity(32'h7F);

        // Long receiver hold-off while the sender keeps offering.
        hold_off = 1'b1;
        fork
            begin
                repeat (60) @(negedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 8; i++)
                send_item('{cmd: 1'($urandom), key: 16'($urandom_range(0, 3)),
                            value: $urandom}, 0, '0);
        join
        wait_drained();

        // Random part under several capacities.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: write_capacity(32'd64);
                1: write_capacity(32'd1);
                2: write_capacity(32'd4);
                3: write_capacity(32'd100);
                default: write_capacity(32'($urandom_range(3, 20)));
            endcase
            stall_enable = (phase != 2);
            for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
            for (int n = 0; n < 100; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst; b++) begin
                    item.cmd = 1'($urandom);
                    item.key = ($urandom_range(0, 9) < 8) ?
                               key_pool[$urandom_range(0, 15)] : 16'($urandom);
                    item.value = $urandom;
                    send_item(item, 0, '0);
                    n++;
                end
                if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
            end
            wait_drained();
        end

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("lru_key_value_cache_tb: done, clean");
        end else begin
            $display("lru_key_value_cache_tb: done, errors");
        end
        $finish;
    end

endmodule
